// File: rtl/rlsp_pkg.sv
// Shared types and constants of the rank leap-and-shift proposal unit.
`default_nettype none

package rlsp_pkg;

  localparam int RankW    = 7;
  localparam int PosW     = 6;
  localparam int ChoiceW  = 6;
  localparam int CountW   = 7;
  localparam int LeapW    = 6;
  localparam int ProbW    = 33;
  localparam int FracBits = 32;
  localparam int ProdW    = 14;   // n * support size
  localparam int SumW     = 15;   // sum of two such products
  localparam int DenW     = 28;   // product of two such products
  localparam int QuotBits = 33;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  localparam logic [CountW-1:0] CountResetVal = 7'd64;
  localparam logic [LeapW-1:0]  LeapResetVal  = 6'd1;

  localparam logic FuncLoad    = 1'b0;
  localparam logic FuncPropose = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgItemCount = 2'd0,
    CfgLeapSize  = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic               func;
    logic [PosW-1:0]    position;
    logic [RankW-1:0]   rank;
    logic [ChoiceW-1:0] choice;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0]  item_position;
    logic [RankW-1:0] proposed_rank;
    logic [ProbW-1:0] fwd_prob;
    logic [ProbW-1:0] bwd_prob;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic            start;
    logic [SumW-1:0] numer;   // dividend is numer * 2^32
    logic [DenW-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ProbW-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/rlsp_store.sv
// Rank store: single-port write, registered read.
`default_nettype none

module rlsp_store #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  wire logic                      clk_i,
  input  wire logic                      wr_en_i,
  input  wire logic [AddrW-1:0]          wr_addr_i,
  input  wire logic [rlsp_pkg::RankW-1:0] wr_data_i,
  input  wire logic                      rd_en_i,
  input  wire logic [AddrW-1:0]          rd_addr_i,
  output logic      [rlsp_pkg::RankW-1:0] rd_data_o
);
  import rlsp_pkg::*;

  logic [RankW-1:0] mem_q [Depth];
  logic [RankW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/rlsp_div.sv
// Shared restoring divider: one quotient bit per cycle, numer * 2^32 / denom.
`default_nettype none

module rlsp_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rlsp_pkg::div_req_t req_i,
  output rlsp_pkg::div_rsp_t      rsp_o
);
  import rlsp_pkg::*;

  localparam int StepW = $clog2(QuotBits + 1);

  logic                busy_q;
  logic                done_q;
  logic [StepW-1:0]    step_q;
  logic [DenW-1:0]     rem_q;
  logic [DenW-1:0]     den_q;
  logic [FracBits:0]   feed_q;
  logic [ProbW-1:0]    quot_q;

  logic [DenW:0]       trial;
  logic [DenW:0]       diff;
  logic                fits;
  logic [DenW-1:0]     rem_d;

  // Remainder stays below the divisor, so the trial value fits one extra bit.
  assign trial = {rem_q, feed_q[FracBits]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};
  assign rem_d = fits ? diff[DenW-1:0] : trial[DenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= StepW'(QuotBits);
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      // Top bits of numer * 2^32 above the 33 quotient bits seed the remainder.
      rem_q  <= DenW'(req_i.numer >> 1);
      den_q  <= req_i.denom;
      feed_q <= {req_i.numer[0], FracBits'(0)};
    end else if (busy_q) begin
      rem_q  <= rem_d;
      feed_q <= feed_q << 1;
      quot_q <= {quot_q[ProbW-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

// File: rtl/rank_leap_shift_proposal_unit.sv
// Top level of the rank leap-and-shift proposal unit: sequencer, config, output register.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | in        | in_valid_i / in_ready_o  | in_data_i  (rlsp_pkg::in_item_t)
//   out     | out       | out_valid_o / out_ready_i| out_data_o (rlsp_pkg::out_item_t)
//   cfg     | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A load item leaves the unit ready again in the next cycle.
// A propose item reads the old rank, picks the new one, forms the support sizes and
// products, then runs the shared one-bit-per-cycle divider (one quotient when the move
// is by one rank, two otherwise), then reads the store and loads the output per position.
// Output stalls hold the sequencer; a finished last item may wait in the output
// register while the next input item is taken. Config is always ready.
// Reset clears control state and resets the config registers; the rank store is not cleared.
`default_nettype none

module rank_leap_shift_proposal_unit #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire rlsp_pkg::in_item_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output rlsp_pkg::out_item_t                out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rlsp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [rlsp_pkg::CfgDataW-1:0] cfg_data_i
);
  import rlsp_pkg::*;

  localparam int AddrW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_LEAP,
    S_SIZE,
    S_MULB,
    S_MULAB,
    S_DIV1_GO,
    S_DIV1_WAIT,
    S_DIV2_GO,
    S_DIV2_WAIT,
    S_EMIT_RD,
    S_EMIT_WR
  } state_e;

  // Lowest rank of the support around r.
  function automatic logic [CountW-1:0] supp_lo(logic [CountW-1:0] r, logic [LeapW-1:0] lsz);
    return (r > CountW'(lsz)) ? r - CountW'(lsz) : CountW'(1);
  endfunction

  // Highest rank of the support around r, clipped to n.
  function automatic logic [CountW-1:0] supp_hi(logic [CountW-1:0] r, logic [LeapW-1:0] lsz,
                                                logic [CountW-1:0] n);
    logic [CountW:0] s;
    s = {1'b0, r} + (CountW+1)'(lsz);
    return (s < {1'b0, n}) ? s[CountW-1:0] : n;
  endfunction

  function automatic logic [CountW-1:0] supp_size(logic [CountW-1:0] r, logic [LeapW-1:0] lsz,
                                                  logic [CountW-1:0] n);
    return supp_hi(r, lsz, n) - supp_lo(r, lsz);
  endfunction

  state_e            state_q;
  logic [CountW-1:0] item_count_q;
  logic [LeapW-1:0]  leap_size_q;

  logic [CountW-1:0] n_q;
  logic [LeapW-1:0]  lsz_q;
  logic [PosW-1:0]   pos_q;
  logic [ChoiceW-1:0] choice_q;
  logic [CountW-1:0] r_q;
  logic [CountW-1:0] new_r_q;
  logic [CountW-1:0] size_q;
  logic [CountW-1:0] size_new_q;
  logic [ProdW-1:0]  a_q;
  logic [ProdW-1:0]  b_q;
  logic [DenW-1:0]   ab_q;
  logic [SumW-1:0]   sum_q;
  logic              adj_q;
  logic [ProbW-1:0]  pf_q;
  logic [ProbW-1:0]  pb_q;
  logic [CountW-1:0] idx_q;
  out_item_t         out_q;
  logic              out_valid_q;

  logic              in_fire;
  logic [CountW-1:0] n_eff;
  logic [LeapW-1:0]  lsz_eff;
  logic              st_wr_en;
  logic              st_rd_en;
  logic [AddrW-1:0]  st_rd_addr;
  logic [RankW-1:0]  st_rd_data;

  logic [CountW-1:0] lo_d;
  logic [CountW-1:0] size_d;
  logic [CountW-1:0] lower_d;
  logic [CountW-1:0] ch_sat_d;
  logic [CountW-1:0] new_r_d;
  logic [CountW-1:0] r_clamp_d;
  logic [RankW-1:0]  shifted_d;
  logic              out_free;
  logic              out_load;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = (state_q == S_EMIT_WR) && out_free;

  // Effective item count and leap size.
  always_comb begin
    n_eff = item_count_q;
    if (item_count_q < CountW'(2)) begin
      n_eff = CountW'(2);
    end else if (int'(item_count_q) > MAX_ITEMS) begin
      n_eff = CountW'(MAX_ITEMS);
    end
  end
  assign lsz_eff = (leap_size_q == '0) ? LeapW'(1) : leap_size_q;

  // Store access: loads and the leaped rank read happen on accept, the rest while emitting.
  assign st_wr_en   = in_fire && (in_data_i.func == FuncLoad) &&
                      (int'(in_data_i.position) < MAX_ITEMS);
  assign st_rd_en   = (in_fire && (in_data_i.func == FuncPropose)) || (state_q == S_EMIT_RD);
  assign st_rd_addr = (state_q == S_IDLE) ? AddrW'(in_data_i.position) : AddrW'(idx_q);

  rlsp_store #(
    .Depth (MAX_ITEMS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (AddrW'(in_data_i.position)),
    .wr_data_i (in_data_i.rank),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (st_rd_addr),
    .rd_data_o (st_rd_data)
  );

  // Old rank clamped into 1..n.
  always_comb begin
    r_clamp_d = st_rd_data;
    if (st_rd_data == '0) begin
      r_clamp_d = CountW'(1);
    end else if (st_rd_data > n_q) begin
      r_clamp_d = n_q;
    end
  end

  // Leap: pick the new rank from the support, lower part first, choice saturated.
  always_comb begin
    lo_d     = supp_lo(r_q, lsz_q);
    size_d   = supp_size(r_q, lsz_q, n_q);
    lower_d  = r_q - lo_d;
    ch_sat_d = ({1'b0, choice_q} >= size_d) ? size_d - CountW'(1) : {1'b0, choice_q};
    new_r_d  = (ch_sat_d < lower_d) ? lo_d + ch_sat_d
                                    : r_q + CountW'(1) + (ch_sat_d - lower_d);
  end

  // Shift: ranks between old and new move one step toward the old rank.
  always_comb begin
    shifted_d = st_rd_data;
    if (idx_q == {1'b0, pos_q}) begin
      shifted_d = new_r_q;
    end else if (new_r_q > r_q && st_rd_data > r_q && st_rd_data <= new_r_q) begin
      shifted_d = st_rd_data - RankW'(1);
    end else if (new_r_q < r_q && st_rd_data >= new_r_q && st_rd_data < r_q) begin
      shifted_d = st_rd_data + RankW'(1);
    end
  end

  // Divider requests: with a one-rank move both probabilities share one quotient.
  always_comb begin
    div_req.start = 1'b0;
    div_req.numer = SumW'(1);
    div_req.denom = DenW'(a_q);
    if (state_q == S_DIV1_GO) begin
      div_req.start = 1'b1;
      if (adj_q) begin
        div_req.numer = sum_q;
        div_req.denom = ab_q;
      end
    end else if (state_q == S_DIV2_GO) begin
      div_req.start = 1'b1;
      div_req.denom = DenW'(b_q);
    end
  end

  rlsp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      item_count_q <= CountResetVal;
      leap_size_q  <= LeapResetVal;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CfgItemCount: item_count_q <= cfg_data_i;
          CfgLeapSize:  leap_size_q  <= cfg_data_i[LeapW-1:0];
          default: ;
        endcase
      end

      // Load the output register, or drain it once the item is taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          // Drop a propose item whose position is not below the effective item count.
          if (in_fire && in_data_i.func == FuncPropose && {1'b0, in_data_i.position} < n_eff) begin
            n_q      <= n_eff;
            lsz_q    <= lsz_eff;
            pos_q    <= in_data_i.position;
            choice_q <= in_data_i.choice;
            state_q  <= S_READ;
          end
        end
        S_READ: begin
          r_q     <= r_clamp_d;
          state_q <= S_LEAP;
        end
        S_LEAP: begin
          new_r_q <= new_r_d;
          size_q  <= size_d;
          state_q <= S_SIZE;
        end
        S_SIZE: begin
          size_new_q <= supp_size(new_r_q, lsz_q, n_q);
          a_q        <= ProdW'(n_q) * ProdW'(size_q);
          adj_q      <= ({1'b0, new_r_q} == {1'b0, r_q} + (CountW+1)'(1)) ||
                        ({1'b0, r_q} == {1'b0, new_r_q} + (CountW+1)'(1));
          state_q    <= S_MULB;
        end
        S_MULB: begin
          b_q     <= ProdW'(n_q) * ProdW'(size_new_q);
          state_q <= S_MULAB;
        end
        S_MULAB: begin
          ab_q    <= DenW'(a_q) * DenW'(b_q);
          sum_q   <= SumW'(a_q) + SumW'(b_q);
          state_q <= S_DIV1_GO;
        end
        S_DIV1_GO: begin
          state_q <= S_DIV1_WAIT;
        end
        S_DIV1_WAIT: begin
          if (div_rsp.done) begin
            pf_q <= div_rsp.quot;
            if (adj_q) begin
              pb_q    <= div_rsp.quot;
              idx_q   <= '0;
              state_q <= S_EMIT_RD;
            end else begin
              state_q <= S_DIV2_GO;
            end
          end
        end
        S_DIV2_GO: begin
          state_q <= S_DIV2_WAIT;
        end
        S_DIV2_WAIT: begin
          if (div_rsp.done) begin
            pb_q    <= div_rsp.quot;
            idx_q   <= '0;
            state_q <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state_q <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          // Hold until the output register is free.
          if (out_free) begin
            out_q.item_position <= idx_q[PosW-1:0];
            out_q.proposed_rank <= shifted_d;
            out_q.fwd_prob      <= pf_q;
            out_q.bwd_prob      <= pb_q;
            out_q.last          <= (idx_q == n_q - CountW'(1));
            if (idx_q == n_q - CountW'(1)) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + CountW'(1);
              state_q <= S_EMIT_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/rlsp_checker.sv
// Port-level checks of the rank leap-and-shift proposal unit, bound to the top level.
`default_nettype none

module rlsp_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire rlsp_pkg::in_item_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire rlsp_pkg::out_item_t out_data_o
);
  import rlsp_pkg::*;

  // A stalled item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  // Probabilities never exceed 1.0.
  a_prob_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.fwd_prob[FracBits] && |out_data_o.fwd_prob[FracBits-1:0])
                 && !(out_data_o.bwd_prob[FracBits] && |out_data_o.bwd_prob[FracBits-1:0]))
    else $error("proposal probability above one");

  // After a load the unit is ready again in the next cycle.
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.func == FuncLoad |=> in_ready_o)
    else $error("unit busy after a load");

  // No input is taken while a proposal is still streaming.
  a_busy_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("input ready in the middle of a proposal");

endmodule

bind rank_leap_shift_proposal_unit rlsp_checker u_rlsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
